FILE: rtl/cdq_pkg.sv
// Package for the circular deque: operation and status codes, controller states
// and the memory command struct. It has no dependencies.
`default_nettype none

package cdq_pkg;

  // Width of one stored element.
  localparam int unsigned DataW = 32;

  // Operation codes carried by a request.
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_PEEK       = 3'd4
  } op_e;

  // Status codes returned with every result.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_FETCH = 2'd1,
    S_RESP  = 2'd2
  } state_e;

  // Strobes from the controller to the slot memory.
  typedef struct packed {
    logic we;
    logic re;
  } mem_cmd_t;

endpackage : cdq_pkg

`default_nettype wire

FILE: rtl/cdq_ram.sv
// Slot memory of the circular deque: one write port and one read port with a
// registered read. Depends on cdq_pkg.
`default_nettype none

module cdq_ram #(
  parameter int unsigned Depth = 8,
  parameter int unsigned IdxW  = 3
) (
  input  wire logic                             clk_i,
  input  wire cdq_pkg::mem_cmd_t                cmd_i,
  input  wire logic [IdxW-1:0]                  waddr_i,
  input  wire logic signed [cdq_pkg::DataW-1:0] wdata_i,
  input  wire logic [IdxW-1:0]                  raddr_i,
  output logic signed [cdq_pkg::DataW-1:0]      rdata_o
);

  logic signed [cdq_pkg::DataW-1:0] mem_q [Depth];
  logic signed [cdq_pkg::DataW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk_i) begin
    if (cmd_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : cdq_ram

`default_nettype wire

FILE: rtl/cdq_ctrl.sv
// Controller of the circular deque: indices, element count, cached end values
// and the request/result sequencing. Depends on cdq_pkg; drives cdq_ram.
`default_nettype none

module cdq_ctrl #(
  parameter int unsigned Depth = 8,
  parameter int unsigned IdxW  = 3,
  parameter int unsigned CntW  = 4
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Request side.
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [2:0]                       operation_i,
  input  wire logic signed [cdq_pkg::DataW-1:0] push_value_i,
  // Result side.
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [1:0]                            status_o,
  output logic signed [cdq_pkg::DataW-1:0]      front_value_o,
  output logic signed [cdq_pkg::DataW-1:0]      rear_value_o,
  output logic [3:0]                            occupancy_o,
  output logic                                  is_empty_o,
  output logic                                  is_full_o,
  // Slot memory.
  output cdq_pkg::mem_cmd_t                     mem_cmd_o,
  output logic [IdxW-1:0]                       mem_waddr_o,
  output logic signed [cdq_pkg::DataW-1:0]      mem_wdata_o,
  output logic [IdxW-1:0]                       mem_raddr_o,
  input  wire logic signed [cdq_pkg::DataW-1:0] mem_rdata_i
);

  localparam logic [IdxW-1:0] LastIdx  = IdxW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt  = CntW'(Depth);
  localparam logic [CntW-1:0] OneCnt   = CntW'(1);

  cdq_pkg::state_e                  state_q, state_d;
  logic [IdxW-1:0]                  fidx_q, fidx_d, ridx_q, ridx_d;
  logic [CntW-1:0]                  cnt_q, cnt_d;
  logic signed [cdq_pkg::DataW-1:0] front_q, front_d, rear_q, rear_d;
  cdq_pkg::status_e                 status_q, status_d;
  logic                             fetch_front_q, fetch_front_d;

  logic            accept;
  logic            empty, full;
  logic [IdxW-1:0] fidx_inc, fidx_dec, ridx_inc, ridx_dec;

  assign accept = in_valid_i && in_ready_o;
  assign empty  = (cnt_q == '0);
  assign full   = (cnt_q == FullCnt);

  // Ring index arithmetic, wrapping at either end.
  assign fidx_inc = (fidx_q == LastIdx) ? '0 : fidx_q + IdxW'(1);
  assign fidx_dec = (fidx_q == '0) ? LastIdx : fidx_q - IdxW'(1);
  assign ridx_inc = (ridx_q == LastIdx) ? '0 : ridx_q + IdxW'(1);
  assign ridx_dec = (ridx_q == '0) ? LastIdx : ridx_q - IdxW'(1);

  // Operation decode: index and count update, slot write or slot read.
  always_comb begin
    fidx_d        = fidx_q;
    ridx_d        = ridx_q;
    cnt_d         = cnt_q;
    front_d       = front_q;
    rear_d        = rear_q;
    status_d      = status_q;
    fetch_front_d = fetch_front_q;
    mem_cmd_o     = '0;
    mem_waddr_o   = '0;
    mem_wdata_o   = push_value_i;
    mem_raddr_o   = '0;

    if (accept) begin
      status_d = cdq_pkg::ST_DONE;
      unique case (operation_i) inside
        cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR: begin
          if (full) begin
            status_d = cdq_pkg::ST_FULL;
          end else begin
            mem_cmd_o.we = 1'b1;
            cnt_d        = cnt_q + OneCnt;
            if (empty) begin
              fidx_d  = '0;
              ridx_d  = '0;
              front_d = push_value_i;
              rear_d  = push_value_i;
            end else if (operation_i == cdq_pkg::OP_PUSH_FRONT) begin
              fidx_d      = fidx_dec;
              mem_waddr_o = fidx_dec;
              front_d     = push_value_i;
            end else begin
              ridx_d      = ridx_inc;
              mem_waddr_o = ridx_inc;
              rear_d      = push_value_i;
            end
          end
        end
        cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_REAR: begin
          if (empty) begin
            status_d = cdq_pkg::ST_EMPTY;
          end else begin
            cnt_d = cnt_q - OneCnt;
            if (cnt_q == OneCnt) begin
              fidx_d = '0;
              ridx_d = '0;
            end else if (operation_i == cdq_pkg::OP_POP_FRONT) begin
              // The new front end is fetched from its slot.
              fidx_d        = fidx_inc;
              mem_cmd_o.re  = 1'b1;
              mem_raddr_o   = fidx_inc;
              fetch_front_d = 1'b1;
            end else begin
              ridx_d        = ridx_dec;
              mem_cmd_o.re  = 1'b1;
              mem_raddr_o   = ridx_dec;
              fetch_front_d = 1'b0;
            end
          end
        end
        default: begin
          // Peek and the unused codes leave the indices, count and end values alone.
        end
      endcase
    end else if (state_q == cdq_pkg::S_FETCH) begin
      if (fetch_front_q) begin
        front_d = mem_rdata_i;
      end else begin
        rear_d = mem_rdata_i;
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cdq_pkg::S_IDLE: begin
        if (accept) begin
          state_d = mem_cmd_o.re ? cdq_pkg::S_FETCH : cdq_pkg::S_RESP;
        end
      end
      cdq_pkg::S_FETCH: begin
        state_d = cdq_pkg::S_RESP;
      end
      cdq_pkg::S_RESP: begin
        if (out_ready_i) begin
          state_d = cdq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cdq_pkg::S_IDLE;
      end
    endcase
  end

  // Handshake and result outputs.
  always_comb begin
    in_ready_o    = (state_q == cdq_pkg::S_IDLE);
    out_valid_o   = (state_q == cdq_pkg::S_RESP);
    status_o      = status_q;
    front_value_o = empty ? '0 : front_q;
    rear_value_o  = empty ? '0 : rear_q;
    occupancy_o   = 4'(cnt_q);
    is_empty_o    = empty;
    is_full_o     = full;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cdq_pkg::S_IDLE;
      fidx_q  <= '0;
      ridx_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      fidx_q  <= fidx_d;
      ridx_q  <= ridx_d;
      cnt_q   <= cnt_d;
    end
  end

  // Cached end values and result payload.
  always_ff @(posedge clk_i) begin
    front_q       <= front_d;
    rear_q        <= rear_d;
    status_q      <= status_d;
    fetch_front_q <= fetch_front_d;
  end

  // The count never passes the ring size.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= FullCnt)
    else $error("deque count above depth");

  // An empty deque keeps both indices at slot zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty |-> (fidx_q == '0) && (ridx_q == '0))
    else $error("empty deque with non-zero index");

  // A slot is never written and read in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_cmd_o.we && mem_cmd_o.re))
    else $error("slot write and read together");

  // A fetch always follows an accepted pop that leaves elements behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cdq_pkg::S_FETCH) |-> $past(accept) && !empty)
    else $error("fetch without a pop");

endmodule : cdq_ctrl

`default_nettype wire

FILE: rtl/circular_deque_unit.sv
// Top level of the circular deque: controller plus slot memory.
// Depends on cdq_pkg, cdq_ctrl and cdq_ram.
//
//   Channel   Direction  Handshake               Fields
//   request   in         in_valid_i/in_ready_o   operation_i, push_value_i
//   result    out        out_valid_o/out_ready_i status_o, front_value_o, rear_value_o,
//                                                occupancy_o, is_empty_o, is_full_o
//
// One request is in flight at a time. A push, peek or refused request shows its
// result in the cycle after acceptance; a pop that leaves elements behind first
// passes through S_FETCH to read the new end value from the slot memory's registered
// read port. The block then takes the next request in the cycle after the result is
// taken. Reset empties the deque at once; the slot memory is not cleared. A stalled
// result holds until out_ready_i is seen.
`default_nettype none

module circular_deque_unit #(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  operation_i,
  input  wire logic signed [31:0] push_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic signed [31:0] front_value_o,
  output logic signed [31:0] rear_value_o,
  output logic [3:0]       occupancy_o,
  output logic             is_empty_o,
  output logic             is_full_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cdq_pkg::mem_cmd_t                mem_cmd;
  logic [IdxW-1:0]                  mem_waddr, mem_raddr;
  logic signed [cdq_pkg::DataW-1:0] mem_wdata, mem_rdata;

  cdq_ctrl #(
    .Depth(DEPTH),
    .IdxW (IdxW),
    .CntW (CntW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .push_value_i (push_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .front_value_o(front_value_o),
    .rear_value_o (rear_value_o),
    .occupancy_o  (occupancy_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o),
    .mem_cmd_o    (mem_cmd),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  cdq_ram #(
    .Depth(DEPTH),
    .IdxW (IdxW)
  ) u_ram (
    .clk_i  (clk_i),
    .cmd_i  (mem_cmd),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule : circular_deque_unit

`default_nettype wire
